@@ rtl/rcwt_pkg.sv @@
// Shared types and constants for the raycast wall texture column block.
// Used by rcwt_ctrl and the top module; depends on nothing else.
`timescale 1ns / 1ps

package rcwt_pkg;

  // Fixed field widths
  localparam int ROW_W    = 13;   // row counters, wide enough for draw_limit
  localparam int PIX_W    = 12;   // screen row / column
  localparam int TEX_W    = 10;   // texel coordinate
  localparam int STEP_W   = 32;   // row step, unsigned
  localparam int POS_W    = 44;   // row position, two's complement
  localparam int OFF_W    = 17;   // signed start offset in rows
  localparam int FRAC_W   = 16;   // wall fraction width
  localparam int LH_W     = 16;   // line height width
  localparam int LG_W     = 4;    // texture size log2 register
  localparam int SH_W     = 12;   // screen height register
  localparam int CFG_W    = 12;   // configuration data width
  localparam int DIV_XTRA = 11;   // dividend bits above the fraction (size up to 2^10)

  // Texture size log2 limits
  localparam logic [LG_W-1:0] LG_MIN = 4'd1;
  localparam logic [LG_W-1:0] LG_MAX = 4'd10;

  // Register reset values
  localparam logic [LG_W-1:0] LG_RESET = 4'd6;
  localparam logic [SH_W-1:0] SH_RESET = 12'd480;

  // Register indexes
  localparam logic REG_TEX_SIZE_LOG2 = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  // Commands
  localparam logic CMD_BEGIN = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Texture codes
  localparam logic [1:0] TEX_NORTH = 2'd0;
  localparam logic [1:0] TEX_SOUTH = 2'd1;
  localparam logic [1:0] TEX_EAST  = 2'd2;
  localparam logic [1:0] TEX_WEST  = 2'd3;

  typedef struct packed {
    logic              command;
    logic              hit_side;
    logic              ray_x_negative;
    logic              ray_y_positive;
    logic [FRAC_W-1:0] wall_fraction;
    logic [LH_W-1:0]   slice_height;
    logic [PIX_W-1:0]  draw_first;
    logic [ROW_W-1:0]  draw_limit;
    logic [PIX_W-1:0]  screen_column;
  } cmd_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_row;
    logic [PIX_W-1:0] pixel_column;
    logic [1:0]       texture_select;
    logic [TEX_W-1:0] texel_x;
    logic [TEX_W-1:0] texel_y;
    logic             darken;
    logic             last_row;
  } texel_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL
  } state_t;

  // Sequencer controls toward the datapath
  typedef struct packed {
    logic idle;
    logic div_en;
    logic div_last;
    logic mul_en;
    logic mul_last;
  } ctl_t;

endpackage

@@ rtl/rcwt_alu.sv @@
// Shared add/subtract unit of the raycast wall texture column block.
// Serves divider trials, multiplier accumulation and row advance; width set by parameter W.
`timescale 1ns / 1ps

module rcwt_alu #(
  parameter int W = 44
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] y
);

  // Subtract as add of the inverted operand plus one
  assign y = a + (b ^ {W{sub}}) + W'(sub);

endmodule

@@ rtl/rcwt_ctrl.sv @@
// Sequencer for the column setup: divide phase, then multiply phase.
// Depends on rcwt_pkg for the state and control types.
`timescale 1ns / 1ps

module rcwt_ctrl #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output rcwt_pkg::ctl_t ctl
);
  import rcwt_pkg::*;

  localparam int NUMW  = FRAC_BITS + DIV_XTRA;
  localparam int CNT_W = $clog2(NUMW);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             div_done;
  logic             mul_done;

  assign div_done = (cnt == CNT_W'(NUMW - 1));
  assign mul_done = (cnt == CNT_W'(OFF_W - 1));

  // Next state and iteration count
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (start) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_MUL;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          state_next = ST_IDLE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  // Control outputs
  always_comb begin
    ctl = '0;
    case (state)
      ST_IDLE: begin
        ctl.idle = 1'b1;
      end
      ST_DIV: begin
        ctl.div_en   = 1'b1;
        ctl.div_last = div_done;
      end
      ST_MUL: begin
        ctl.mul_en   = 1'b1;
        ctl.mul_last = mul_done;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

@@ rtl/raycast_wall_texture_column.sv @@
// Raycast wall texture column: texel address generator for one screen column.
// Step item: result registered if rows remain; one step item per cycle when cmd_stall is low.
// Begin item: busy while the sequencer runs its divide and multiply phases: one quotient
// bit a cycle for the row step, then shift-add over the 17-bit offset for the start position,
// both through the single 44-bit add/subtract unit. Synchronous active-high reset clears
// sequencer, column and output-valid state and sets tex_size_log2 = 6, screen_height = 480.
`timescale 1ns / 1ps

module raycast_wall_texture_column #(
  parameter int FRAC_BITS   = 16,
  parameter int SCREEN_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  rcwt_pkg::cmd_t                cmd,
  output logic                          texel_valid,
  input  logic                          texel_stall,
  output rcwt_pkg::texel_t              texel,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [rcwt_pkg::CFG_W-1:0]    cfg_data
);
  import rcwt_pkg::*;

  localparam int NUMW = FRAC_BITS + DIV_XTRA;
  localparam int QW   = ((NUMW > STEP_W) ? NUMW : STEP_W) + 1;
  localparam logic [ROW_W:0] ROW_CAP = (ROW_W + 1)'(1) << SCREEN_BITS;

  // Configuration registers
  logic [LG_W-1:0] tex_size_log2;
  logic [SH_W-1:0] screen_height;

  // Column state
  logic [1:0]        texture_pick;
  logic [TEX_W-1:0]  texture_column;
  logic [STEP_W-1:0] row_step;
  logic [POS_W-1:0]  row_position;
  logic [ROW_W-1:0]  current_row;
  logic [ROW_W-1:0]  end_row;
  logic [PIX_W-1:0]  column_held;

  // Divider and multiplier working registers
  logic [NUMW-1:0]  dividend;
  logic [LH_W-1:0]  divisor;
  logic [LH_W-1:0]  rem;
  logic [QW-1:0]    quot;
  logic [OFF_W-1:0] offset;
  logic [POS_W-1:0] mcand;

  ctl_t ctl;

  logic              take;
  logic              start;
  logic              step_take;
  logic              emit;
  logic [LG_W-1:0]   lg;
  logic [TEX_W-1:0]  size_mask;
  logic [1:0]        pick_in;
  logic [TEX_W-1:0]  col_raw;
  logic [LH_W-1:0]   lh_eff;
  logic [OFF_W-1:0]  offset_in;
  logic [ROW_W-1:0]  end_in;
  logic [LH_W:0]     rem_shift;
  logic              ge;
  logic [QW-1:0]     quot_next;
  logic [STEP_W-1:0] step_sat;
  logic [POS_W-1:0]  alu_a;
  logic [POS_W-1:0]  alu_b;
  logic              alu_sub;
  logic [POS_W-1:0]  alu_y;
  texel_t            texel_next;

  // Handshake
  assign cmd_stall = !ctl.idle || (texel_valid && texel_stall);
  assign take      = cmd_valid && !cmd_stall;
  assign start     = take && (cmd.command == CMD_BEGIN);
  assign step_take = take && (cmd.command == CMD_STEP);
  assign emit      = step_take && (current_row < end_row);

  rcwt_ctrl #(
    .FRAC_BITS(FRAC_BITS)
  ) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .ctl  (ctl)
  );

  // Clamp texture size and build its mask
  always_comb begin
    if (tex_size_log2 < LG_MIN) begin
      lg = LG_MIN;
    end else if (tex_size_log2 > LG_MAX) begin
      lg = LG_MAX;
    end else begin
      lg = tex_size_log2;
    end
    size_mask = TEX_W'(((TEX_W + 1)'(1) << lg) - (TEX_W + 1)'(1));
  end

  // Decode the ray hit for a begin item
  always_comb begin
    if (cmd.hit_side == 1'b0) begin
      pick_in = cmd.ray_x_negative ? TEX_WEST : TEX_EAST;
    end else begin
      pick_in = cmd.ray_y_positive ? TEX_SOUTH : TEX_NORTH;
    end
    col_raw = TEX_W'(cmd.wall_fraction >> (5'd16 - 5'(lg)));
    if (pick_in == TEX_WEST || pick_in == TEX_SOUTH) begin
      col_raw = col_raw ^ size_mask;
    end
    lh_eff    = (cmd.slice_height == '0) ? LH_W'(1) : cmd.slice_height;
    offset_in = OFF_W'(cmd.draw_first) - OFF_W'(screen_height[SH_W-1:1])
                + OFF_W'(lh_eff[LH_W-1:1]);
    if ((ROW_W + 1)'(cmd.draw_limit) > ROW_CAP) begin
      end_in = ROW_CAP[ROW_W-1:0];
    end else begin
      end_in = cmd.draw_limit;
    end
  end

  // Divider trial: shifted remainder against the divisor
  assign rem_shift = {rem, dividend[NUMW-1]};
  assign ge        = !alu_y[POS_W-1];
  assign quot_next = {quot[QW-2:0], ge};
  assign step_sat  = (|quot_next[QW-1:STEP_W]) ? '1 : quot_next[STEP_W-1:0];

  // Route the shared adder
  always_comb begin
    if (ctl.div_en) begin
      alu_a   = POS_W'(rem_shift);
      alu_b   = POS_W'(divisor);
      alu_sub = 1'b1;
    end else if (ctl.mul_en) begin
      alu_a   = row_position;
      alu_b   = mcand;
      alu_sub = ctl.mul_last;
    end else begin
      alu_a   = row_position;
      alu_b   = POS_W'(row_step);
      alu_sub = 1'b0;
    end
  end

  rcwt_alu #(
    .W(POS_W)
  ) u_alu (
    .a  (alu_a),
    .b  (alu_b),
    .sub(alu_sub),
    .y  (alu_y)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tex_size_log2 <= LG_RESET;
      screen_height <= SH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TEX_SIZE_LOG2: tex_size_log2 <= cfg_data[LG_W-1:0];
        REG_SCREEN_HEIGHT: screen_height <= cfg_data[SH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Column state: latch on begin, load row step and start position, advance on each emitted row
  always_ff @(posedge clk) begin
    if (rst) begin
      texture_pick   <= '0;
      texture_column <= '0;
      row_step       <= '0;
      row_position   <= '0;
      current_row    <= '0;
      end_row        <= '0;
      column_held    <= '0;
    end else begin
      if (start) begin
        texture_pick   <= pick_in;
        texture_column <= col_raw;
        current_row    <= ROW_W'(cmd.draw_first);
        end_row        <= end_in;
        column_held    <= cmd.screen_column;
      end else if (emit) begin
        row_position <= alu_y;
        current_row  <= current_row + ROW_W'(1);
      end
      if (ctl.div_last) begin
        row_step     <= step_sat;
        row_position <= '0;
      end else if (ctl.mul_en && offset[0]) begin
        row_position <= alu_y;
      end
    end
  end

  // Divider and multiplier working registers
  always_ff @(posedge clk) begin
    if (start) begin
      dividend <= NUMW'(1) << (FRAC_BITS + int'(lg));
      divisor  <= lh_eff;
      rem      <= '0;
      quot     <= '0;
      offset   <= offset_in;
    end else if (ctl.div_en) begin
      dividend <= dividend << 1;
      rem      <= ge ? alu_y[LH_W-1:0] : rem_shift[LH_W-1:0];
      quot     <= quot_next;
      if (ctl.div_last) begin
        mcand <= POS_W'(step_sat);
      end
    end else if (ctl.mul_en) begin
      offset <= offset >> 1;
      mcand  <= mcand << 1;
    end
  end

  // Result for one row
  always_comb begin
    texel_next.pixel_row      = current_row[PIX_W-1:0];
    texel_next.pixel_column   = column_held;
    texel_next.texture_select = texture_pick;
    texel_next.texel_x        = texture_column;
    texel_next.texel_y        = row_position[FRAC_BITS +: TEX_W] & size_mask;
    texel_next.darken         = (texture_pick == TEX_NORTH) || (texture_pick == TEX_EAST);
    texel_next.last_row       = ((ROW_W + 1)'(current_row) + (ROW_W + 1)'(1))
                                >= (ROW_W + 1)'(end_row);
  end

  // Output register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      texel_valid <= 1'b0;
    end else if (emit) begin
      texel_valid <= 1'b1;
    end else if (!texel_stall) begin
      texel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      texel <= texel_next;
    end
  end

  // A begin item always occupies the sequencer on the next cycle
  a_begin_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> cmd_stall)
    else $error("begin item did not occupy the sequencer");

  // A new result only follows an accepted step item
  a_result_from_step: assert property (@(posedge clk) disable iff (rst)
    $rose(texel_valid) |-> $past(cmd_valid && !cmd_stall && cmd.command == CMD_STEP))
    else $error("result appeared without a step item");

  // The final row of a column leaves no rows behind it
  a_last_row_end: assert property (@(posedge clk) disable iff (rst)
    (texel_valid && texel.last_row) |-> (current_row == end_row))
    else $error("last row flagged while rows remain");

endmodule
